@@ hw/rtl/dcss_pkg.sv @@
package dcss_pkg;

  // Converter and burst geometry.
  localparam int ADC_FULL_SCALE   = 1023;
  localparam int SAMPLE_W         = 10;
  localparam int NUM_SAMPLES      = 10;
  localparam int NUM_LANES        = 5;
  localparam int SAMPLES_PER_LANE = NUM_SAMPLES / NUM_LANES;
  localparam int PART_W           = SAMPLE_W + $clog2(SAMPLES_PER_LANE);
  localparam int SUM_W            = SAMPLE_W + $clog2(NUM_SAMPLES);

  // Division by ten as a multiply by a scaled reciprocal; exact for sums below 2^14.
  localparam int AVG_RECIP   = 6554;
  localparam int AVG_SHIFT   = 16;
  localparam int AVG_RECIP_W = 13;

  // Time and calibration constants.
  localparam int MS_PER_SECOND = 1000;
  localparam int PERCENT_MAX   = 100;
  localparam int NOW_W         = 32;
  localparam int TIME_W        = 34;
  localparam int INTERVAL_W    = 17;
  localparam int INTERVAL_MS_W = 27;
  localparam int SETTLE_W      = 16;
  localparam int PERCENT_W     = 7;

  // Calibration divider: |avg - dry| * 100 by |wet - dry|.
  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W  = SAMPLE_W;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = INTERVAL_W;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLING_ENABLED = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_SECONDS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_DELAY_MS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DRY_POINT        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WET_POINT        = 3'd4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 17'd5;
  localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = 16'(3 * MS_PER_SECOND);
  localparam logic [SAMPLE_W-1:0]   DRY_RESET      = SAMPLE_W'(ADC_FULL_SCALE);
  localparam logic [SAMPLE_W-1:0]   WET_RESET      = '0;

  // Action codes reported with each result item.
  localparam logic [1:0] ACT_IDLE     = 2'd0;
  localparam logic [1:0] ACT_POWER_ON = 2'd1;
  localparam logic [1:0] ACT_SETTLING = 2'd2;
  localparam logic [1:0] ACT_READ     = 2'd3;

  typedef struct packed {
    logic [1:0]           action;
    logic                 power_on;
    logic [SAMPLE_W-1:0]  raw_level;
    logic [PERCENT_W-1:0] moisture_percent;
    logic                 calibration_fault;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/dcss_if.sv @@
// Poll channel: one time stamp and a burst of converter samples per item.
interface dcss_poll_if import dcss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NOW_W-1:0]    now_ms;
  logic [SAMPLE_W-1:0] sample_0;
  logic [SAMPLE_W-1:0] sample_1;
  logic [SAMPLE_W-1:0] sample_2;
  logic [SAMPLE_W-1:0] sample_3;
  logic [SAMPLE_W-1:0] sample_4;
  logic [SAMPLE_W-1:0] sample_5;
  logic [SAMPLE_W-1:0] sample_6;
  logic [SAMPLE_W-1:0] sample_7;
  logic [SAMPLE_W-1:0] sample_8;
  logic [SAMPLE_W-1:0] sample_9;

  modport source (
    output valid, now_ms, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8, sample_9,
    input  ready
  );
  modport sink (
    input  valid, now_ms, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8, sample_9,
    output ready
  );
endinterface

// Result channel: one item per poll.
interface dcss_result_if import dcss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic                 power_on;
  logic [SAMPLE_W-1:0]  raw_level;
  logic [PERCENT_W-1:0] moisture_percent;
  logic                 calibration_fault;

  modport source (
    output valid, action, power_on, raw_level, moisture_percent, calibration_fault,
    input  ready
  );
  modport sink (
    input  valid, action, power_on, raw_level, moisture_percent, calibration_fault,
    output ready
  );
endinterface

// Configuration write channel.
interface dcss_cfg_if import dcss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dcss_lane.sv @@
// One summing lane: adds its share of the burst when a poll is taken.
module dcss_lane import dcss_pkg::*; (
  input  logic                clk,
  input  logic                load,
  input  logic [SAMPLE_W-1:0] samples [SAMPLES_PER_LANE],
  output logic [PART_W-1:0]   partial
);

  logic [PART_W-1:0] acc;

  // Partial sum of the lane's samples.
  always_comb begin
    acc = '0;
    for (int i = 0; i < SAMPLES_PER_LANE; i++) begin
      acc = acc + PART_W'(samples[i]);
    end
  end

  // Hold the partial sum until the next poll.
  always_ff @(posedge clk) begin
    if (load) begin
      partial <= acc;
    end
  end

endmodule

@@ hw/rtl/dcss_merge.sv @@
// Merges the lane sums and divides the total by the burst length.
module dcss_merge import dcss_pkg::*; (
  input  logic                clk,
  input  logic [PART_W-1:0]   partial [NUM_LANES],
  output logic [SAMPLE_W-1:0] avg
);

  logic [SUM_W-1:0]             sum_next;
  logic [SUM_W-1:0]             sum;
  logic [SUM_W+AVG_RECIP_W-1:0] prod;

  // Add the lane results.
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_next = sum_next + SUM_W'(partial[i]);
    end
  end

  // Truncating divide by ten via the scaled reciprocal.
  assign prod = (SUM_W+AVG_RECIP_W)'(sum) * (SUM_W+AVG_RECIP_W)'(AVG_RECIP);

  // Registered sum, then registered average.
  always_ff @(posedge clk) begin
    sum <= sum_next;
    avg <= prod[AVG_SHIFT +: SAMPLE_W];
  end

endmodule

@@ hw/rtl/dcss_div.sv @@
// Restoring divider, one quotient bit per cycle.
module dcss_div import dcss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  // Control: count down the quotient bits, flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ hw/rtl/duty_cycled_sensor_sampler_top.sv @@
// Channel   Dir  Payload                                               Accept
// poll      in   now_ms, sample_0 .. sample_9                          valid && ready
// result    out  action, power_on, raw_level, moisture_percent,        valid && ready
//                calibration_fault
// cfg       in   index, data                                           valid && ready
//
// A poll that takes no reading goes through ST_TIME and ST_DECIDE to ST_OUT, which loads
// its result item; a reading that needs no division (fault or clamped to zero) adds ST_CAL.
// A reading that needs division also waits in ST_DIV for the one-bit-per-cycle divider
// that maps the average onto the calibration range.
// One poll is in flight at a time; poll.ready is high only while the block waits for one.
// A finished item waits in the output register while result.ready is low.
// Reset (rst, synchronous) restores register defaults with the sensor powered, never read.
module duty_cycled_sensor_sampler_top import dcss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dcss_poll_if.sink   poll,
  dcss_result_if.source result,
  dcss_cfg_if.sink    cfg
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_TIME   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_CAL    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic                  sampling_enabled;
  logic [INTERVAL_W-1:0] interval_seconds;
  logic [SETTLE_W-1:0]   settle_delay_ms;
  logic [SAMPLE_W-1:0]   dry_point;
  logic [SAMPLE_W-1:0]   wet_point;

  // Sampler state.
  logic                     sensor_powered;
  logic [NOW_W-1:0]         power_on_time;
  logic signed [TIME_W-1:0] last_reading_time;
  logic [SAMPLE_W-1:0]      held_raw;
  logic [PERCENT_W-1:0]     held_percent;

  // Per-poll working registers.
  logic [NOW_W-1:0]         now_q;
  logic [INTERVAL_MS_W-1:0] interval_ms;
  logic [1:0]               action;
  logic                     fault;
  result_t                  res;
  logic                     res_valid;

  logic                poll_take;
  logic                out_free;
  logic [SAMPLE_W-1:0] samples [NUM_SAMPLES];
  logic [PART_W-1:0]   partial [NUM_LANES];
  logic [SAMPLE_W-1:0] avg;

  assign poll_take = poll.valid && poll.ready;
  assign poll.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign out_free   = !res_valid || result.ready;

  assign samples[0] = poll.sample_0;
  assign samples[1] = poll.sample_1;
  assign samples[2] = poll.sample_2;
  assign samples[3] = poll.sample_3;
  assign samples[4] = poll.sample_4;
  assign samples[5] = poll.sample_5;
  assign samples[6] = poll.sample_6;
  assign samples[7] = poll.sample_7;
  assign samples[8] = poll.sample_8;
  assign samples[9] = poll.sample_9;

  // Summing lanes, each over its own slice of the burst.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [SAMPLE_W-1:0] lane_samples [SAMPLES_PER_LANE];
    for (genvar k = 0; k < SAMPLES_PER_LANE; k++) begin : g_tap
      assign lane_samples[k] = samples[g*SAMPLES_PER_LANE + k];
    end
    dcss_lane u_lane (
      .clk     (clk),
      .load    (poll_take),
      .samples (lane_samples),
      .partial (partial[g])
    );
  end

  dcss_merge u_merge (
    .clk     (clk),
    .partial (partial),
    .avg     (avg)
  );

  // Timing decisions, made with the registered interval.
  logic signed [TIME_W-1:0] due_limit;
  logic signed [TIME_W-1:0] now_s;
  logic signed [TIME_W-1:0] settle_s;
  logic [NOW_W:0]           settle_end;
  logic                     due;
  logic                     cycling;
  logic                     settled;

  assign now_s      = $signed({{(TIME_W-NOW_W){1'b0}}, now_q});
  assign settle_s   = $signed({{(TIME_W-SETTLE_W){1'b0}}, settle_delay_ms});
  assign due_limit  = last_reading_time + $signed({{(TIME_W-INTERVAL_MS_W){1'b0}}, interval_ms});
  assign due        = (due_limit < now_s) || (last_reading_time == '0);
  assign cycling    = interval_ms > INTERVAL_MS_W'(settle_delay_ms);
  assign settle_end = {1'b0, power_on_time} + (NOW_W+1)'(settle_delay_ms);
  assign settled    = settle_end < {1'b0, now_q};

  // Calibration operands from the fresh average.
  logic signed [SAMPLE_W:0] num;
  logic signed [SAMPLE_W:0] den;
  logic [SAMPLE_W-1:0]      num_mag;
  logic [SAMPLE_W-1:0]      den_mag;
  logic                     cal_zero;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign num      = $signed({1'b0, avg}) - $signed({1'b0, dry_point});
  assign den      = $signed({1'b0, wet_point}) - $signed({1'b0, dry_point});
  assign num_mag  = num[SAMPLE_W] ? SAMPLE_W'(-num) : num[SAMPLE_W-1:0];
  assign den_mag  = den[SAMPLE_W] ? SAMPLE_W'(-den) : den[SAMPLE_W-1:0];
  // A zero or negative quotient clamps to zero and needs no division.
  assign cal_zero = (num == '0) || (num[SAMPLE_W] != den[SAMPLE_W]);

  assign div_req.start    = (state == ST_CAL) && (den != '0) && !cal_zero;
  assign div_req.dividend = (DIVIDEND_W'(num_mag) << 6) + (DIVIDEND_W'(num_mag) << 5)
                          + (DIVIDEND_W'(num_mag) << 2);
  assign div_req.divisor  = den_mag;

  dcss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_enabled <= 1'b1;
      interval_seconds <= INTERVAL_RESET;
      settle_delay_ms  <= SETTLE_RESET;
      dry_point        <= DRY_RESET;
      wet_point        <= WET_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SAMPLING_ENABLED: sampling_enabled <= cfg.data[0];
        REG_INTERVAL_SECONDS: interval_seconds <= cfg.data[INTERVAL_W-1:0];
        REG_SETTLE_DELAY_MS:  settle_delay_ms  <= cfg.data[SETTLE_W-1:0];
        REG_DRY_POINT:        dry_point        <= cfg.data[SAMPLE_W-1:0];
        REG_WET_POINT:        wet_point        <= cfg.data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Poll sequencer and sampler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      sensor_powered    <= 1'b1;
      power_on_time     <= '0;
      last_reading_time <= '0;
      held_raw          <= '0;
      held_percent      <= '0;
      res_valid         <= 1'b0;
    end else begin
      // The output register empties unless a new item replaces it this cycle.
      if (res_valid && result.ready && (state != ST_OUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (poll_take) begin
            now_q <= poll.now_ms;
            state <= ST_TIME;
          end
        end
        ST_TIME: begin
          interval_ms <= INTERVAL_MS_W'(interval_seconds) * INTERVAL_MS_W'(MS_PER_SECOND);
          state       <= ST_DECIDE;
        end
        ST_DECIDE: begin
          fault <= 1'b0;
          state <= ST_OUT;
          if (!(due && sampling_enabled)) begin
            action <= ACT_IDLE;
          end else if (!sensor_powered) begin
            sensor_powered <= 1'b1;
            power_on_time  <= now_q;
            action         <= ACT_POWER_ON;
          end else if (cycling && !settled) begin
            action <= ACT_SETTLING;
          end else begin
            last_reading_time <= cycling ? (now_s - settle_s) : now_s;
            if (cycling) begin
              sensor_powered <= 1'b0;
            end
            action <= ACT_READ;
            state  <= ST_CAL;
          end
        end
        ST_CAL: begin
          held_raw <= avg;
          if (den == '0) begin
            held_percent <= '0;
            fault        <= 1'b1;
            state        <= ST_OUT;
          end else if (cal_zero) begin
            held_percent <= '0;
            state        <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            held_percent <= (div_rsp.quotient > DIVIDEND_W'(PERCENT_MAX))
                            ? PERCENT_W'(PERCENT_MAX) : div_rsp.quotient[PERCENT_W-1:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res.action            <= action;
            res.power_on          <= sensor_powered;
            res.raw_level         <= held_raw;
            res.moisture_percent  <= held_percent;
            res.calibration_fault <= fault;
            res_valid             <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid             = res_valid;
  assign result.action            = res.action;
  assign result.power_on          = res.power_on;
  assign result.raw_level         = res.raw_level;
  assign result.moisture_percent  = res.moisture_percent;
  assign result.calibration_fault = res.calibration_fault;

  // A fault is only reported on a poll that took a reading.
  a_fault_on_read: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.calibration_fault |-> result.action == ACT_READ)
    else $error("calibration fault without a reading");

  // The held percentage never leaves its clamped range.
  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.moisture_percent <= PERCENT_W'(PERCENT_MAX))
    else $error("moisture percent above full scale");

  // Powering on always leaves the sensor powered.
  a_power_on: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.action == ACT_POWER_ON |-> result.power_on)
    else $error("power-on action with sensor unpowered");

  // Only one poll is in flight at a time.
  a_one_poll: assert property (@(posedge clk) disable iff (rst)
    poll.valid && poll.ready |=> !poll.ready)
    else $error("second poll taken while one is in flight");

endmodule

@@ verif/tb_duty_cycled_sensor_sampler_top.sv @@
module tb_duty_cycled_sensor_sampler_top;
  import dcss_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 700;
  localparam int DRAIN_CYCLES = 25;
  localparam int REPORT_MAX   = 10;

  localparam logic [SAMPLE_W-1:0] CHECKER_A = 10'h2AA;
  localparam logic [SAMPLE_W-1:0] CHECKER_B = 10'h155;

  // Ways of filling the ten converter samples of one burst.
  typedef enum int {
    SH_ZERO,
    SH_FULL,
    SH_CHECKER,
    SH_CHECKER_INV,
    SH_CLUSTER,
    SH_SCATTER
  } burst_shape_e;

  typedef struct packed {
    logic [NOW_W-1:0]                     now_ms;
    logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] samples;
  } poll_t;

  logic clk = 1'b0;
  logic rst;

  dcss_poll_if   poll_ch ();
  dcss_result_if res_ch ();
  dcss_cfg_if    cfg_ch ();

  duty_cycled_sensor_sampler_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic                  cfg_enabled;
  logic [INTERVAL_W-1:0] cfg_interval_s;
  logic [SETTLE_W-1:0]   cfg_settle_ms;
  logic [SAMPLE_W-1:0]   cfg_dry;
  logic [SAMPLE_W-1:0]   cfg_wet;

  // Shadow copy of the sensor and reading state.
  logic                     sensor_on;
  logic [NOW_W-1:0]         powered_at_ms;
  logic signed [TIME_W-1:0] last_read_ms;
  logic [SAMPLE_W-1:0]      held_raw;
  logic [PERCENT_W-1:0]     held_pct;

  poll_t   polls_to_send[$];
  result_t outcomes_pending[$];
  poll_t   next_poll;
  poll_t   arrived_poll;
  result_t seen_result;
  result_t due_result;

  longint time_cursor;
  int     polls_accepted = 0;
  int     error_count = 0;
  int     stall_cycles = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  bit     poll_fired = 1'b0;

  // Idle share of each side: sender light and receiver heavy, then swapped, then none.
  function automatic int idle_pct(bit sender);
    if (polls_accepted < 320) return sender ? 24 : 61;
    if (polls_accepted < 640) return sender ? 61 : 24;
    return 0;
  endfunction

  // Advances the shadow state by one poll and returns the result item it should produce.
  function automatic result_t poll_outcome(poll_t p);
    result_t r;
    longint  now_v, interval_ms, settle_v, on_v, sum_v, avg_v, dry_v, wet_v, pct;
    bit      due, cycling, settled;
    int      i;
    now_v       = longint'(p.now_ms);
    interval_ms = longint'(cfg_interval_s);
    interval_ms = interval_ms * MS_PER_SECOND;
    settle_v    = longint'(cfg_settle_ms);
    on_v        = longint'(powered_at_ms);
    due         = (longint'(last_read_ms) + interval_ms < now_v) || (last_read_ms == '0);
    cycling     = interval_ms > settle_v;
    settled     = on_v + settle_v < now_v;
    r = '0;
    r.action = ACT_IDLE;
    if (due && cfg_enabled) begin
      if (!sensor_on) begin
        sensor_on     = 1'b1;
        powered_at_ms = p.now_ms;
        r.action      = ACT_POWER_ON;
      end else if (cycling && !settled) begin
        r.action = ACT_SETTLING;
      end else begin
        sum_v = 0;
        for (i = 0; i < NUM_SAMPLES; i++) sum_v += longint'(p.samples[i]);
        avg_v        = sum_v / NUM_SAMPLES;
        held_raw     = SAMPLE_W'(avg_v);
        last_read_ms = TIME_W'(cycling ? now_v - settle_v : now_v);
        dry_v        = longint'(cfg_dry);
        wet_v        = longint'(cfg_wet);
        // Equal calibration points would divide by zero, so the percentage is forced to 0.
        if (dry_v == wet_v) begin
          held_pct            = '0;
          r.calibration_fault = 1'b1;
        end else begin
          pct = ((avg_v - dry_v) * PERCENT_MAX) / (wet_v - dry_v);
          if (pct < 0) pct = 0;
          if (pct > PERCENT_MAX) pct = PERCENT_MAX;
          held_pct = PERCENT_W'(pct);
        end
        if (cycling) sensor_on = 1'b0;
        r.action = ACT_READ;
      end
    end
    r.power_on         = sensor_on;
    r.raw_level        = held_raw;
    r.moisture_percent = held_pct;
    return r;
  endfunction

  // Builds one poll item with the given time and sample shape and queues it for the driver.
  task automatic queue_poll(input logic [NOW_W-1:0] now, input burst_shape_e shape);
    poll_t p;
    int    center;
    int    v;
    int    i;
    center   = $urandom_range(ADC_FULL_SCALE);
    p.now_ms = now;
    for (i = 0; i < NUM_SAMPLES; i++) begin
      case (shape)
        SH_ZERO:        v = 0;
        SH_FULL:        v = ADC_FULL_SCALE;
        SH_CHECKER:     v = (i % 2 == 0) ? int'(CHECKER_A) : int'(CHECKER_B);
        SH_CHECKER_INV: v = (i % 2 == 0) ? int'(CHECKER_B) : int'(CHECKER_A);
        SH_CLUSTER: begin
          v = center + int'($urandom_range(40)) - 20;
          if (v < 0) v = 0;
          if (v > ADC_FULL_SCALE) v = ADC_FULL_SCALE;
        end
        default:        v = $urandom_range(ADC_FULL_SCALE);
      endcase
      p.samples[i] = SAMPLE_W'(v);
    end
    polls_to_send.push_back(p);
  endtask

  // Writes one register and mirrors it into the shadow copy once the write is accepted.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_SAMPLING_ENABLED: cfg_enabled    = value[0];
      REG_INTERVAL_SECONDS: cfg_interval_s = value[INTERVAL_W-1:0];
      REG_SETTLE_DELAY_MS:  cfg_settle_ms  = value[SETTLE_W-1:0];
      REG_DRY_POINT:        cfg_dry        = value[SAMPLE_W-1:0];
      REG_WET_POINT:        cfg_wet        = value[SAMPLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Writes every register, with random bits above each field narrower than the data word, plus one unmapped index.
  task automatic configure(input bit en, input int unsigned interval_s,
                           input int unsigned settle, input int unsigned dry,
                           input int unsigned wet);
    write_reg(REG_SAMPLING_ENABLED, CFG_DATA_W'({$urandom, en}));
    write_reg(REG_INTERVAL_SECONDS, CFG_DATA_W'(interval_s));
    write_reg(REG_SETTLE_DELAY_MS, CFG_DATA_W'({$urandom, settle[SETTLE_W-1:0]}));
    write_reg(REG_DRY_POINT, CFG_DATA_W'({$urandom, dry[SAMPLE_W-1:0]}));
    write_reg(REG_WET_POINT, CFG_DATA_W'({$urandom, wet[SAMPLE_W-1:0]}));
    write_reg(CFG_INDEX_W'(REG_WET_POINT + 1 + $urandom_range(2)), CFG_DATA_W'($urandom));
  endtask

  // Waits until every queued item has gone through and its result has come back.
  // The check runs at the rising edge, where the driver never changes the queue or valid.
  task automatic wait_idle();
    while (polls_to_send.size() != 0 || poll_ch.valid || outcomes_pending.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly a forward clock in steps scaled to the larger of interval and settle delay,
  // so the sensor powers on, settles and reads; some polls repeat or go back in time.
  task automatic run_random(input int count);
    int unsigned      scale;
    int unsigned      pick;
    int               n;
    longint           next_t;
    logic [NOW_W-1:0] now;
    burst_shape_e     shape;
    scale = cfg_interval_s * MS_PER_SECOND;
    if (cfg_settle_ms > scale) scale = 32'(cfg_settle_ms);
    if (scale < 30) scale = 30;
    for (n = 0; n < count; n++) begin
      pick   = $urandom_range(99);
      next_t = time_cursor;
      if (pick < 80) next_t += longint'($urandom_range(scale / 3));
      else if (pick < 90) next_t += longint'(scale + $urandom_range(scale));
      if (next_t <= 64'hFFFF_FFFF) time_cursor = next_t;
      if (pick >= 95) now = $urandom_range(time_cursor[NOW_W-1:0]);
      else now = time_cursor[NOW_W-1:0];
      pick  = $urandom_range(9);
      shape = (pick < 6) ? SH_CLUSTER :
              (pick < 9) ? SH_SCATTER : burst_shape_e'($urandom_range(SH_CHECKER_INV));
      queue_poll(now, shape);
    end
    wait_idle();
  endtask

  // Driver: presents queued polls, holding each one until it is accepted.
  always @(negedge clk) begin
    if (rst) begin
      poll_ch.valid <= 1'b0;
    end else if (!poll_ch.valid || poll_fired) begin
      if (polls_to_send.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        next_poll = polls_to_send.pop_front();
        poll_ch.valid    <= 1'b1;
        poll_ch.now_ms   <= next_poll.now_ms;
        poll_ch.sample_0 <= next_poll.samples[0];
        poll_ch.sample_1 <= next_poll.samples[1];
        poll_ch.sample_2 <= next_poll.samples[2];
        poll_ch.sample_3 <= next_poll.samples[3];
        poll_ch.sample_4 <= next_poll.samples[4];
        poll_ch.sample_5 <= next_poll.samples[5];
        poll_ch.sample_6 <= next_poll.samples[6];
        poll_ch.sample_7 <= next_poll.samples[7];
        poll_ch.sample_8 <= next_poll.samples[8];
        poll_ch.sample_9 <= next_poll.samples[9];
      end else begin
        poll_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, with one long hold-off partway through the run.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && polls_accepted >= HOLD_AFTER) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Monitor: checks each result item, predicts each accepted poll and watches for a hang.
  always @(posedge clk) begin
    if (rst) begin
      poll_fired   <= 1'b0;
      stall_cycles <= 0;
    end else begin
      poll_fired <= poll_ch.valid && poll_ch.ready;

      if (res_ch.valid && res_ch.ready) begin
        seen_result.action            = res_ch.action;
        seen_result.power_on          = res_ch.power_on;
        seen_result.raw_level         = res_ch.raw_level;
        seen_result.moisture_percent  = res_ch.moisture_percent;
        seen_result.calibration_fault = res_ch.calibration_fault;
        if (outcomes_pending.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("ERROR: result item with no poll outstanding: action=%0d raw=%0d pct=%0d",
                     seen_result.action, seen_result.raw_level, seen_result.moisture_percent);
        end else begin
          due_result = outcomes_pending.pop_front();
          if (seen_result.action !== due_result.action ||
              seen_result.power_on !== due_result.power_on ||
              seen_result.raw_level !== due_result.raw_level ||
              seen_result.moisture_percent !== due_result.moisture_percent ||
              seen_result.calibration_fault !== due_result.calibration_fault) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
              $display("ERROR: result mismatch: expected action=%0d power_on=%0d raw=%0d pct=%0d fault=%0d",
                       due_result.action, due_result.power_on, due_result.raw_level,
                       due_result.moisture_percent, due_result.calibration_fault);
              $display("       got                  action=%0d power_on=%0d raw=%0d pct=%0d fault=%0d",
                       seen_result.action, seen_result.power_on, seen_result.raw_level,
                       seen_result.moisture_percent, seen_result.calibration_fault);
            end
          end
        end
      end

      if (poll_ch.valid && poll_ch.ready) begin
        arrived_poll.now_ms     = poll_ch.now_ms;
        arrived_poll.samples[0] = poll_ch.sample_0;
        arrived_poll.samples[1] = poll_ch.sample_1;
        arrived_poll.samples[2] = poll_ch.sample_2;
        arrived_poll.samples[3] = poll_ch.sample_3;
        arrived_poll.samples[4] = poll_ch.sample_4;
        arrived_poll.samples[5] = poll_ch.sample_5;
        arrived_poll.samples[6] = poll_ch.sample_6;
        arrived_poll.samples[7] = poll_ch.sample_7;
        arrived_poll.samples[8] = poll_ch.sample_8;
        arrived_poll.samples[9] = poll_ch.sample_9;
        outcomes_pending.push_back(poll_outcome(arrived_poll));
        polls_accepted++;
      end

      // Any accepted item on any channel counts as progress.
      if ((poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no item accepted for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus sequence: reset, directed polls, then random phases under several settings.
  initial begin
    rst              = 1'b1;
    poll_ch.valid    = 1'b0;
    poll_ch.now_ms   = '0;
    poll_ch.sample_0 = '0;
    poll_ch.sample_1 = '0;
    poll_ch.sample_2 = '0;
    poll_ch.sample_3 = '0;
    poll_ch.sample_4 = '0;
    poll_ch.sample_5 = '0;
    poll_ch.sample_6 = '0;
    poll_ch.sample_7 = '0;
    poll_ch.sample_8 = '0;
    poll_ch.sample_9 = '0;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;

    cfg_enabled    = 1'b1;
    cfg_interval_s = INTERVAL_RESET;
    cfg_settle_ms  = SETTLE_RESET;
    cfg_dry        = DRY_RESET;
    cfg_wet        = WET_RESET;
    sensor_on      = 1'b1;
    powered_at_ms  = '0;
    last_read_ms   = '0;
    held_raw       = '0;
    held_pct       = '0;
    time_cursor    = 20000;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With the sensor always on, a reading at time zero leaves the block in the never-read
    // state, so the next poll at time zero reads again.
    write_reg(REG_SETTLE_DELAY_MS, CFG_DATA_W'(16'hFFFF));
    queue_poll(32'd0, SH_FULL);
    queue_poll(32'd0, SH_ZERO);
    wait_idle();

    // Default settings: settle boundaries, interval boundaries and a full power cycle.
    write_reg(REG_SETTLE_DELAY_MS, CFG_DATA_W'(SETTLE_RESET));
    queue_poll(32'd0, SH_CHECKER);
    queue_poll(32'd3000, SH_CHECKER_INV);
    queue_poll(32'd3001, SH_FULL);
    queue_poll(32'd5001, SH_SCATTER);
    queue_poll(32'd5002, SH_SCATTER);
    queue_poll(32'd8002, SH_SCATTER);
    queue_poll(32'd8003, SH_ZERO);
    queue_poll(32'd10003, SH_FULL);
    queue_poll(32'd10004, SH_ZERO);
    queue_poll(32'd13005, SH_CHECKER);
    queue_poll(32'd15006, SH_CHECKER_INV);
    queue_poll(32'd18007, SH_SCATTER);
    queue_poll(32'd18007, SH_CLUSTER);
    wait_idle();

    configure(1'b1, 5, 3000, 1023, 0);
    run_random(100);
    // Interval shorter than the settle delay keeps the sensor powered.
    configure(1'b1, 1, 65535, 0, 1023);
    run_random(100);
    configure(1'b1, 2, 1000, 512, 512);
    run_random(100);
    configure(1'b0, 3, 3000, 0, 0);
    run_random(40);
    // Interval equal to the settle delay is not duty-cycled.
    configure(1'b1, 3, 3000, 1023, 1023);
    run_random(100);
    configure(1'b1, 0, 0, 300, 700);
    run_random(100);
    repeat (3) begin
      configure(1'b1, $urandom_range(1, 30), $urandom_range(0, 40000),
                $urandom_range(ADC_FULL_SCALE), $urandom_range(ADC_FULL_SCALE));
      run_random(100);
    end
    configure(1'b1, 86400, 0, 700, 200);
    run_random(50);
    // Jump the clock into the upper half of the counter range for the widest interval.
    if (time_cursor < 64'h8000_0000) time_cursor = 64'h8000_0000 + $urandom_range(1000000);
    configure(1'b1, 131071, 65535, 1, 1022);
    run_random(40);

    // Largest time stamp, then a step back to zero.
    queue_poll(32'hFFFF_FFFF, SH_SCATTER);
    queue_poll(32'hFFFF_FFFF, SH_SCATTER);
    queue_poll(32'd0, SH_SCATTER);
    wait_idle();

    if (error_count == 0 && outcomes_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dcss_pkg.sv
hw/rtl/dcss_if.sv
hw/rtl/dcss_lane.sv
hw/rtl/dcss_merge.sv
hw/rtl/dcss_div.sv
hw/rtl/duty_cycled_sensor_sampler_top.sv
verif/tb_duty_cycled_sensor_sampler_top.sv
